>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Define NO_ASSERTIONS to compile every macro to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/hsv_pkg.sv
// Types and constants of the HSV to RGB converter.
// No dependencies.
package hsv_pkg;

    localparam int STAGES = 5;

    localparam logic [11:0] HUE_FULL   = 12'd3600;
    localparam logic [9:0]  HUE_SECTOR = 10'd600;
    localparam logic [7:0]  FULL_SCALE = 8'd255;

    // x channel divisor 600*255 and its reciprocal, floor(2^44 / 153000)
    localparam int          X_SHIFT = 44;
    localparam logic [17:0] X_DIV   = 18'd153000;
    localparam logic [26:0] X_RECIP = 27'((64'd1 << X_SHIFT) / 64'd153000);

    // 257/65536 under-approximates 1/255 by less than one unit
    localparam logic [8:0]  Z_RECIP = 9'd257;

    // 60-degree hue sectors
    typedef enum logic [2:0] {
        SEC_RED_YELLOW,
        SEC_YELLOW_GREEN,
        SEC_GREEN_CYAN,
        SEC_CYAN_BLUE,
        SEC_BLUE_MAGENTA,
        SEC_MAGENTA_RED
    } hsv_sector_t;

    // Pipeline control: per-stage load enables, valid flags and input ready
    typedef struct packed {
        logic [STAGES-1:0] load;
        logic [STAGES-1:0] valid;
        logic              in_ready;
    } hsv_pipe_ctl_t;

endpackage

>>> rtl/hsv_in_if.sv
// Input channel: valid/ready handshake carrying one HSV color.
// No dependencies.
interface hsv_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] hue_tenths;
    logic [7:0]  saturation;
    logic [7:0]  value_level;

    modport source (output valid, hue_tenths, saturation, value_level, input ready);
    modport sink   (input valid, hue_tenths, saturation, value_level, output ready);
endinterface

>>> rtl/hsv_out_if.sv
// Output channel: valid/ready handshake carrying one RGB color.
// No dependencies.
interface hsv_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

>>> rtl/hsv_pipe_ctl.sv
// Valid flags and load enables of the converter pipeline.
// Depends on hsv_pkg.
module hsv_pipe_ctl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  out_ready,
    output hsv_pkg::hsv_pipe_ctl_t ctl
);

    logic [hsv_pkg::STAGES-1:0] valid_reg;
    logic [hsv_pkg::STAGES-1:0] valid_next;
    logic [hsv_pkg::STAGES-1:0] load;

    // A stage loads when it is empty or its content moves on this cycle
    always_comb
    begin
        load[hsv_pkg::STAGES-1] = !valid_reg[hsv_pkg::STAGES-1] || out_ready;
        for (int i = hsv_pkg::STAGES - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    always_comb
    begin
        if (load[0])
            valid_next[0] = in_valid;
        else
            valid_next[0] = valid_reg[0];
        for (int i = 1; i < hsv_pkg::STAGES; i++)
        begin
            if (load[i])
                valid_next[i] = valid_reg[i-1];
            else
                valid_next[i] = valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign ctl.load     = load;
    assign ctl.valid    = valid_reg;
    assign ctl.in_ready = load[0];

endmodule

>>> rtl/hsv_to_rgb_converter_top.sv
// HSV to RGB converter, five-stage pipeline, one color per cycle unless stalled.
// Depends on hsv_pkg, hsv_in_if, hsv_out_if, hsv_pipe_ctl, assert_macros.svh.
//
//  channel  | dir | fields                                   | handshake
//  ---------+-----+------------------------------------------+------------
//  hsv_in   | in  | hue_tenths[11:0] saturation[7:0]         | valid/ready
//           |     | value_level[7:0]                         |
//  rgb_out  | out | red[7:0] green[7:0] blue[7:0]            | valid/ready
//
// Each color passes stages 1 to 5 to the output; one enters per cycle
// unless stalled. The five register stages are set by the two chained
// multiplies and the reciprocal divide by 153000 with its correction step.
// Reset clears only the stage valid flags. A stall at the output fills
// empty stages first, then holds each full stage; nothing is dropped.
`include "assert_macros.svh"

module hsv_to_rgb_converter_top (
    input  logic           clk,
    input  logic           rst_n,
    hsv_in_if.sink         hsv_in,
    hsv_out_if.source      rgb_out
);

    hsv_pkg::hsv_pipe_ctl_t ctl;

    hsv_pipe_ctl u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hsv_in.valid),
        .out_ready (rgb_out.ready),
        .ctl       (ctl)
    );

    assign hsv_in.ready = ctl.in_ready;

    // ---------------- stage 1: hue wrap, sector and ramp position
    logic [11:0]          hue_wrap;
    hsv_pkg::hsv_sector_t sector_c;
    logic [11:0]          sector_base;
    logic [9:0]           offset_c;
    logic [9:0]           ramp_c;

    hsv_pkg::hsv_sector_t s1_sector_reg;
    logic [9:0]           s1_ramp_reg;
    logic [7:0]           s1_sat_reg;
    logic [7:0]           s1_val_reg;

    always_comb
    begin
        hue_wrap = (hsv_in.hue_tenths >= hsv_pkg::HUE_FULL) ?
                   hsv_in.hue_tenths - hsv_pkg::HUE_FULL : hsv_in.hue_tenths;
        priority if (hue_wrap >= 12'd3000)
        begin
            sector_c    = hsv_pkg::SEC_MAGENTA_RED;
            sector_base = 12'd3000;
        end
        else if (hue_wrap >= 12'd2400)
        begin
            sector_c    = hsv_pkg::SEC_BLUE_MAGENTA;
            sector_base = 12'd2400;
        end
        else if (hue_wrap >= 12'd1800)
        begin
            sector_c    = hsv_pkg::SEC_CYAN_BLUE;
            sector_base = 12'd1800;
        end
        else if (hue_wrap >= 12'd1200)
        begin
            sector_c    = hsv_pkg::SEC_GREEN_CYAN;
            sector_base = 12'd1200;
        end
        else if (hue_wrap >= 12'd600)
        begin
            sector_c    = hsv_pkg::SEC_YELLOW_GREEN;
            sector_base = 12'd600;
        end
        else
        begin
            sector_c    = hsv_pkg::SEC_RED_YELLOW;
            sector_base = 12'd0;
        end
        offset_c = 10'(hue_wrap - sector_base);
        // rising ramp in even sectors, falling in odd ones
        ramp_c   = sector_c[0] ? hsv_pkg::HUE_SECTOR - offset_c : offset_c;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            s1_sector_reg <= sector_c;
            s1_ramp_reg   <= ramp_c;
            s1_sat_reg    <= hsv_in.saturation;
            s1_val_reg    <= hsv_in.value_level;
        end
    end

    // ---------------- stage 2: x weight and zero-channel numerator
    logic [7:0]  inv_sat;
    logic [17:0] weight_c;
    logic [15:0] zero_num_c;

    hsv_pkg::hsv_sector_t s2_sector_reg;
    logic [17:0]          s2_weight_reg;
    logic [15:0]          s2_zero_num_reg;
    logic [7:0]           s2_val_reg;

    always_comb
    begin
        inv_sat    = hsv_pkg::FULL_SCALE - s1_sat_reg;
        weight_c   = 18'(s1_sat_reg) * 18'(s1_ramp_reg)
                   + 18'(hsv_pkg::HUE_SECTOR) * 18'(inv_sat);
        zero_num_c = 16'(s1_val_reg) * 16'(inv_sat);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[1])
        begin
            s2_sector_reg   <= s1_sector_reg;
            s2_weight_reg   <= weight_c;
            s2_zero_num_reg <= zero_num_c;
            s2_val_reg      <= s1_val_reg;
        end
    end

    // ---------------- stage 3: x numerator and zero-channel estimate
    logic [25:0] x_num_c;
    logic [24:0] zero_prod_c;

    hsv_pkg::hsv_sector_t s3_sector_reg;
    logic [25:0]          s3_x_num_reg;
    logic [15:0]          s3_zero_num_reg;
    logic [7:0]           s3_zero_est_reg;
    logic [7:0]           s3_val_reg;

    always_comb
    begin
        x_num_c     = 26'(s2_val_reg) * 26'(s2_weight_reg);
        zero_prod_c = 25'(s2_zero_num_reg) * 25'(hsv_pkg::Z_RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[2])
        begin
            s3_sector_reg   <= s2_sector_reg;
            s3_x_num_reg    <= x_num_c;
            s3_zero_num_reg <= s2_zero_num_reg;
            s3_zero_est_reg <= zero_prod_c[23:16];
            s3_val_reg      <= s2_val_reg;
        end
    end

    // ---------------- stage 4: x estimate, zero-channel correction
    logic [52:0] x_prod_c;
    logic [15:0] zero_rem_c;
    logic [7:0]  zero_c;

    hsv_pkg::hsv_sector_t s4_sector_reg;
    logic [25:0]          s4_x_num_reg;
    logic [7:0]           s4_x_est_reg;
    logic [7:0]           s4_zero_reg;
    logic [7:0]           s4_val_reg;

    always_comb
    begin
        x_prod_c   = 53'(s3_x_num_reg) * 53'(hsv_pkg::X_RECIP);
        zero_rem_c = s3_zero_num_reg - 16'(s3_zero_est_reg) * 16'(hsv_pkg::FULL_SCALE);
        // estimate is low by at most one
        zero_c     = (zero_rem_c >= 16'(hsv_pkg::FULL_SCALE)) ?
                     s3_zero_est_reg + 8'd1 : s3_zero_est_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[3])
        begin
            s4_sector_reg <= s3_sector_reg;
            s4_x_num_reg  <= s3_x_num_reg;
            s4_x_est_reg  <= x_prod_c[hsv_pkg::X_SHIFT +: 8];
            s4_zero_reg   <= zero_c;
            s4_val_reg    <= s3_val_reg;
        end
    end

    // ---------------- stage 5: x correction and channel routing
    logic [25:0] x_rem_c;
    logic [7:0]  x_c;
    logic [7:0]  red_next;
    logic [7:0]  green_next;
    logic [7:0]  blue_next;

    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;

    always_comb
    begin
        x_rem_c = s4_x_num_reg - 26'(s4_x_est_reg) * 26'(hsv_pkg::X_DIV);
        x_c     = (x_rem_c >= 26'(hsv_pkg::X_DIV)) ? s4_x_est_reg + 8'd1 : s4_x_est_reg;
        unique case (s4_sector_reg)
            hsv_pkg::SEC_RED_YELLOW:
            begin
                red_next = s4_val_reg; green_next = x_c; blue_next = s4_zero_reg;
            end
            hsv_pkg::SEC_YELLOW_GREEN:
            begin
                red_next = x_c; green_next = s4_val_reg; blue_next = s4_zero_reg;
            end
            hsv_pkg::SEC_GREEN_CYAN:
            begin
                red_next = s4_zero_reg; green_next = s4_val_reg; blue_next = x_c;
            end
            hsv_pkg::SEC_CYAN_BLUE:
            begin
                red_next = s4_zero_reg; green_next = x_c; blue_next = s4_val_reg;
            end
            hsv_pkg::SEC_BLUE_MAGENTA:
            begin
                red_next = x_c; green_next = s4_zero_reg; blue_next = s4_val_reg;
            end
            default:
            begin
                red_next = s4_val_reg; green_next = s4_zero_reg; blue_next = x_c;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[4])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign rgb_out.valid = ctl.valid[4];
    assign rgb_out.red   = red_reg;
    assign rgb_out.green = green_reg;
    assign rgb_out.blue  = blue_reg;

    // ---------------- checks
    `ASSERT_IMPLIES(a_zero_le_value, clk, rst_n, ctl.valid[3], s4_zero_reg <= s4_val_reg)
    `ASSERT_IMPLIES(a_x_est_le_value, clk, rst_n, ctl.valid[3], s4_x_est_reg <= s4_val_reg)
    `ASSERT_IMPLIES(a_ramp_range, clk, rst_n, ctl.valid[0], s1_ramp_reg <= hsv_pkg::HUE_SECTOR)
    `ASSERT_IMPLIES(a_ready_when_drained, clk, rst_n, !ctl.valid[4], hsv_in.ready)

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the HSV to RGB converter pipeline.
// Depends on hsv_pkg, hsv_in_if, hsv_out_if and hsv_to_rgb_converter_top.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HUE_PAIR_TENTHS = 2 * hsv_pkg::HUE_SECTOR;
    localparam int unsigned LIMIT_CYCLES    = 200_000;
    localparam int unsigned HOLD_CYCLES     = 80;
    localparam int unsigned MAX_REPORTS     = 10;
    localparam int unsigned IDLE_PCT        = 6;

    typedef struct packed {
        logic [11:0] hue;
        logic [7:0]  sat;
        logic [7:0]  val;
    } hsv_color_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_color_t;

    typedef struct packed {
        hsv_color_t src;
        rgb_color_t rgb;
    } pending_pixel_t;

    logic clk = 1'b0;
    logic rst_n;

    hsv_in_if  hsv_in ();
    hsv_out_if rgb_out ();

    hsv_to_rgb_converter_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .hsv_in  (hsv_in),
        .rgb_out (rgb_out)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    pending_pixel_t pending_pixels[$];
    int unsigned    colors_sent     = 0;
    int unsigned    colors_checked  = 0;
    int unsigned    mismatch_count  = 0;
    int unsigned    cycle_count     = 0;
    int unsigned    send_idle_pct   = IDLE_PCT;
    int unsigned    recv_stall_pct  = IDLE_PCT;
    logic           hold_request    = 1'b0;
    int unsigned    hold_left       = 0;

    // Expected color for one HSV input, exact integer form of the float math
    function automatic rgb_color_t convert_hsv(hsv_color_t px);
        int unsigned h;
        int unsigned hm;
        int unsigned t;
        int unsigned s;
        int unsigned v;
        int unsigned peak;
        int unsigned ramp;
        int unsigned floor_lvl;
        hsv_pkg::hsv_sector_t sector;
        rgb_color_t  res;
        h = px.hue;
        s = px.sat;
        v = px.val;
        // hues past the circle wrap once
        if (h >= hsv_pkg::HUE_FULL)
            h = h - hsv_pkg::HUE_FULL;
        hm = h % HUE_PAIR_TENTHS;
        t  = (hm >= hsv_pkg::HUE_SECTOR) ? (HUE_PAIR_TENTHS - hm) : hm;
        peak      = v;
        ramp      = (v * s * t + hsv_pkg::HUE_SECTOR * v * (hsv_pkg::FULL_SCALE - s))
                    / (hsv_pkg::HUE_SECTOR * hsv_pkg::FULL_SCALE);
        floor_lvl = (v * (hsv_pkg::FULL_SCALE - s)) / hsv_pkg::FULL_SCALE;
        sector    = hsv_pkg::hsv_sector_t'(h / hsv_pkg::HUE_SECTOR);
        unique case (sector)
            hsv_pkg::SEC_RED_YELLOW:
                res = '{peak[7:0], ramp[7:0], floor_lvl[7:0]};
            hsv_pkg::SEC_YELLOW_GREEN:
                res = '{ramp[7:0], peak[7:0], floor_lvl[7:0]};
            hsv_pkg::SEC_GREEN_CYAN:
                res = '{floor_lvl[7:0], peak[7:0], ramp[7:0]};
            hsv_pkg::SEC_CYAN_BLUE:
                res = '{floor_lvl[7:0], ramp[7:0], peak[7:0]};
            hsv_pkg::SEC_BLUE_MAGENTA:
                res = '{ramp[7:0], floor_lvl[7:0], peak[7:0]};
            default:
                res = '{peak[7:0], floor_lvl[7:0], ramp[7:0]};
        endcase
        return res;
    endfunction

    function automatic void note_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    // Saturation or value level, biased toward the ends of the range
    function automatic logic [7:0] pick_level();
        unique case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic hsv_color_t random_color();
        hsv_color_t px;
        // mostly legal hues, some in the wrap range
        if ($urandom_range(7) == 0)
            px.hue = 12'($urandom_range(4095, 3600));
        else
            px.hue = 12'($urandom_range(3599));
        px.sat = pick_level();
        px.val = pick_level();
        return px;
    endfunction

    // One input transfer; called and returns right after a rising edge
    task automatic send_color(hsv_color_t px);
        if ($urandom_range(99) < send_idle_pct)
        begin
            hsv_in.valid <= 1'b0;
            @(posedge clk);
        end
        hsv_in.valid       <= 1'b1;
        hsv_in.hue_tenths  <= px.hue;
        hsv_in.saturation  <= px.sat;
        hsv_in.value_level <= px.val;
        @(posedge clk);
        while (!hsv_in.ready)
            @(posedge clk);
        pending_pixels.push_back('{px, convert_hsv(px)});
        colors_sent++;
    endtask

    // Sender goes quiet until every expected color is back
    task automatic wait_drained();
        hsv_in.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    // Sector edges, wrap range, grey and black, field extremes
    task automatic test_directed_corners();
        hsv_color_t corners[20];
        corners = '{
            '{12'd0,    8'd255, 8'd255}, '{12'd599,  8'd255, 8'd255},
            '{12'd600,  8'd255, 8'd255}, '{12'd1200, 8'd255, 8'd255},
            '{12'd1800, 8'd255, 8'd255}, '{12'd2400, 8'd255, 8'd255},
            '{12'd3000, 8'd255, 8'd255}, '{12'd3599, 8'd255, 8'd255},
            '{12'd3600, 8'd255, 8'd255}, '{12'd4095, 8'd255, 8'd255},
            '{12'd3000, 8'd0,   8'd200}, '{12'd1234, 8'd200, 8'd0},
            '{12'd0,    8'd0,   8'd0},   '{12'd300,  8'd128, 8'd255},
            '{12'd900,  8'd255, 8'd128}, '{12'd1500, 8'd1,   8'd254},
            '{12'd2100, 8'd170, 8'd85},  '{12'd2700, 8'd85,  8'd170},
            '{12'd3300, 8'd254, 8'd1},   '{12'd4000, 8'd77,  8'd199}
        };
        foreach (corners[i])
            send_color(corners[i]);
    endtask

    // Long random stream; middle part runs at full rate on both sides
    task automatic test_random_stream(int unsigned count);
        for (int unsigned i = 0; i < count; i++)
        begin
            if (i == count / 3)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            else if (i == count / 3 + 300)
            begin
                send_idle_pct  = IDLE_PCT;
                recv_stall_pct = IDLE_PCT;
            end
            send_color(random_color());
        end
    endtask

    // Receiver holds off while the sender keeps offering; pipeline fills
    task automatic test_output_hold(int unsigned rounds, int unsigned count);
        for (int unsigned r = 0; r < rounds; r++)
        begin
            hold_request <= 1'b1;
            for (int unsigned i = 0; i < count; i++)
                send_color(random_color());
        end
    endtask

    // Short bursts, each followed by a full drain of the pipeline
    task automatic test_burst_drain(int unsigned bursts, int unsigned count);
        for (int unsigned b = 0; b < bursts; b++)
        begin
            for (int unsigned i = 0; i < count; i++)
                send_color(random_color());
            wait_drained();
        end
    endtask

    // Result side ready, with random stalls and commanded hold-offs
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request  <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            rgb_out.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            rgb_out.ready <= 1'b0;
        end
        else
            rgb_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each result transfer against the oldest expected color
    always @(posedge clk)
    begin
        pending_pixel_t want;
        rgb_color_t     got;
        if (rst_n && rgb_out.valid && rgb_out.ready)
        begin
            got = '{rgb_out.red, rgb_out.green, rgb_out.blue};
            if (pending_pixels.size() == 0)
                note_failure($sformatf("unexpected color r=%0d g=%0d b=%0d",
                                       got.red, got.green, got.blue));
            else
            begin
                want = pending_pixels.pop_front();
                colors_checked++;
                if (got.red !== want.rgb.red || got.green !== want.rgb.green
                    || got.blue !== want.rgb.blue)
                    note_failure($sformatf(
                        "h=%0d s=%0d v=%0d expected %0d/%0d/%0d got %0d/%0d/%0d",
                        want.src.hue, want.src.sat, want.src.val,
                        want.rgb.red, want.rgb.green, want.rgb.blue,
                        got.red, got.green, got.blue));
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d colors outstanding",
                     cycle_count, pending_pixels.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        hsv_in.valid        = 1'b0;
        hsv_in.hue_tenths   = '0;
        hsv_in.saturation   = '0;
        hsv_in.value_level  = '0;
        rgb_out.ready       = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_random_stream(1300);
        test_output_hold(2, 60);
        test_burst_drain(5, 40);

        // let any stray results surface after the last expected one
        wait_drained();
        repeat (2 * hsv_pkg::STAGES + 4) @(posedge clk);
        if (pending_pixels.size() != 0)
            note_failure($sformatf("%0d colors never came out", pending_pixels.size()));

        $display("Sent %0d colors and checked %0d: all sectors, wrapped hues, grey/black,",
                 colors_sent, colors_checked);
        $display("full-rate streaming, output hold-offs and drain pauses; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/hsv_pkg.sv
rtl/hsv_in_if.sv
rtl/hsv_out_if.sv
rtl/hsv_pipe_ctl.sv
rtl/hsv_to_rgb_converter_top.sv
sim/testbench.sv
